// ----- src/page_free_list_allocator_defines.svh -----
// assertion macros for the allocator checker
`ifndef PAGE_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define PAGE_FREE_LIST_ALLOCATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PFLA_ASSERT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pfla check failed");

// next-cycle implication, checked at every clock
`define PFLA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("pfla check failed");

`endif

// ----- src/pfla_pkg.sv -----
// shared types and codes of the page free list allocator
package pfla_pkg;

   // fixed field widths
   localparam int ADDR_W    = 48;
   localparam int CNT_OUT_W = 15;
   localparam int STAT_W    = 3;
   localparam int ACT_W     = 2;
   localparam int CSR_IDX_W = 1;

   // actions
   localparam logic [ACT_W-1:0] ACT_INIT  = 2'd0;
   localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd1;
   localparam logic [ACT_W-1:0] ACT_FREE  = 2'd2;

   // result status codes
   localparam logic [STAT_W-1:0] ST_OK           = 3'd0;
   localparam logic [STAT_W-1:0] ST_NOT_INIT     = 3'd1;
   localparam logic [STAT_W-1:0] ST_NO_FREE      = 3'd2;
   localparam logic [STAT_W-1:0] ST_UNTRACKED    = 3'd3;
   localparam logic [STAT_W-1:0] ST_EMPTY_REGION = 3'd4;
   localparam logic [STAT_W-1:0] ST_ALREADY_FREE = 3'd5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BASE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE = 1'd1;

   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic [ADDR_W-1:0] page_addr_in;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0]    status;
      logic [ADDR_W-1:0]    page_addr_out;
      logic [CNT_OUT_W-1:0] free_pages;
      logic [CNT_OUT_W-1:0] total_pages;
   } rsp_type;

endpackage

// ----- src/pfla_ram.sv -----
// generic single-port-write ram with registered read
module pfla_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- src/pfla_geom.sv -----
// two-stage region geometry: page-rounded bounds, page count and lowest tracked page
module pfla_geom #(
   parameter int MAX_PAGES  = 16384,
   parameter int PAGE_SHIFT = 12,
   parameter int ADDR_BITS  = 48
) (
   input  logic                                             clock,
   input  logic [pfla_pkg::ADDR_W-1:0]                      region_base,
   input  logic [pfla_pkg::ADDR_W-1:0]                      region_size,
   output logic                                             empty,
   output logic [$clog2(MAX_PAGES+1)-1:0]                   page_count,
   output logic [$clog2(MAX_PAGES)-1:0]                     last_index,
   output logic [pfla_pkg::ADDR_W+1-PAGE_SHIFT-1:0]         top_pn,
   output logic [pfla_pkg::ADDR_W+1-PAGE_SHIFT-1:0]         low_pn
);
   import pfla_pkg::*;

   localparam int IDX_W  = $clog2(MAX_PAGES);
   localparam int CNT_W  = $clog2(MAX_PAGES + 1);
   localparam int SUM_W  = ADDR_W + 1;
   localparam int PN_W   = SUM_W - PAGE_SHIFT;
   localparam int KEEP_W = (ADDR_BITS < SUM_W) ? ADDR_BITS : SUM_W;
   localparam logic [SUM_W-1:0] ADDR_MASK = {SUM_W{1'b1}} >> (SUM_W - KEEP_W);
   localparam logic [SUM_W-1:0] PAGE_LOW  = SUM_W'((64'd1 << PAGE_SHIFT) - 64'd1);
   localparam logic [PN_W:0]    MAX_DIFF  = (PN_W + 1)'(MAX_PAGES);

   logic [SUM_W-1:0] base_sum;
   logic [SUM_W-1:0] top_sum;
   logic [PN_W-1:0]  base_pn_ff;
   logic [PN_W-1:0]  top_pn1_ff;
   logic [PN_W:0]    diff;
   logic             clamp;
   logic [CNT_W-1:0] count_in;
   logic             empty_ff;
   logic [CNT_W-1:0] count_ff;
   logic [IDX_W-1:0] last_ff;
   logic [PN_W-1:0]  top_pn2_ff;
   logic [PN_W-1:0]  low_pn_ff;

   // stage 1: round base up and top down, wrapped to the address width
   assign base_sum = ({1'b0, region_base} + PAGE_LOW) & ADDR_MASK;
   assign top_sum  = ({1'b0, region_base} + {1'b0, region_size}) & ADDR_MASK;

   always_ff @(posedge clock) begin
      base_pn_ff <= base_sum[SUM_W-1:PAGE_SHIFT];
      top_pn1_ff <= top_sum[SUM_W-1:PAGE_SHIFT];
   end

   // stage 2: page count, clamp to capacity
   assign diff     = {1'b0, top_pn1_ff} - {1'b0, base_pn_ff};
   assign clamp    = diff > MAX_DIFF;
   assign count_in = clamp ? CNT_W'(MAX_PAGES) : diff[CNT_W-1:0];

   always_ff @(posedge clock) begin
      empty_ff   <= diff[PN_W] || (diff == '0);
      count_ff   <= count_in;
      last_ff    <= IDX_W'(count_in - CNT_W'(1));
      top_pn2_ff <= top_pn1_ff;
      low_pn_ff  <= clamp ? (top_pn1_ff - PN_W'(MAX_PAGES)) : base_pn_ff;
   end

   assign empty      = empty_ff;
   assign page_count = count_ff;
   assign last_index = last_ff;
   assign top_pn     = top_pn2_ff;
   assign low_pn     = low_pn_ff;
endmodule

// ----- src/page_free_list_allocator.sv -----
// page free list allocator top level: control, state registers and link memory
//
//  channel | direction | transfer at edge with      | payload
//  --------+-----------+----------------------------+-------------------------
//  req     | in        | start && !busy             | req_item (action, addr)
//  rsp     | out       | rsp_valid (one-cycle pulse)| rsp_item (status, counts)
//  csr     | in        | csr_valid && csr_ready     | csr_index, csr_wdata
//
// alloc reads and writes the link memory once; free does a range check and read,
// then a check of the allocated mark and a write back, and ends after the range check
// when the address is untracked; alloc or free before init, alloc with no free page and
// unused actions finish in the request cycle; init computes and checks the geometry,
// ends on an empty region, else writes the list one entry per cycle via its write port.
// the result pulses on rsp_valid the cycle after the last working cycle.
// reset is synchronous; the link memory is not cleared and is only read at
// entries that init has written. the receiver cannot stall results.
module page_free_list_allocator #(
   parameter int MAX_PAGES  = 16384,
   parameter int PAGE_SHIFT = 12,
   parameter int ADDR_BITS  = 48
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  pfla_pkg::req_type                  req_item,
   output logic                               rsp_valid,
   output pfla_pkg::rsp_type                  rsp_item,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pfla_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pfla_pkg::ADDR_W-1:0]        csr_wdata
);
   import pfla_pkg::*;

   localparam int IDX_W  = $clog2(MAX_PAGES);
   localparam int CNT_W  = $clog2(MAX_PAGES + 1);
   localparam int SUM_W  = ADDR_W + 1;
   localparam int PN_W   = SUM_W - PAGE_SHIFT;
   localparam int ENT_W  = IDX_W + 1;
   localparam int KEEP_W = (ADDR_BITS < SUM_W) ? ADDR_BITS : SUM_W;
   localparam logic [SUM_W-1:0] ADDR_MASK = {SUM_W{1'b1}} >> (SUM_W - KEEP_W);

   typedef enum logic [6:0] {
      S_IDLE      = 7'b0000001,
      S_INIT_GEOM = 7'b0000010,
      S_INIT_CHK  = 7'b0000100,
      S_INIT_FILL = 7'b0001000,
      S_ALLOC_WR  = 7'b0010000,
      S_FREE_RD   = 7'b0100000,
      S_FREE_WR   = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] base_ff, size_ff;
   logic              ready_ff, ready_in;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  free_ff, free_in;
   logic [CNT_W-1:0]  tracked_ff, tracked_in;
   logic [PN_W-1:0]   top_ff, top_in;
   logic [PN_W-1:0]   low_ff, low_in;
   logic [IDX_W-1:0]  fill_ff, fill_in;
   logic [IDX_W-1:0]  slot_ff, slot_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              geom_empty;
   logic [CNT_W-1:0]  geom_count;
   logic [IDX_W-1:0]  geom_last;
   logic [PN_W-1:0]   geom_top;
   logic [PN_W-1:0]   geom_low;

   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   logic [ENT_W-1:0]  ram_wr_data;
   logic              ram_rd_en;
   logic [IDX_W-1:0]  ram_rd_addr;
   logic [ENT_W-1:0]  ram_rd_data;

   logic [ADDR_W-1:0] free_addr_m;
   logic [PN_W-1:0]   free_pn;
   logic              free_hit;
   logic [IDX_W-1:0]  free_slot;
   logic [PN_W-1:0]   alloc_pn;
   logic [SUM_W-1:0]  alloc_full;
   logic              done;
   logic [STAT_W-1:0] status_c;
   logic [ADDR_W-1:0] out_addr_c;

   // region geometry from the registers
   pfla_geom #(
      .MAX_PAGES  (MAX_PAGES),
      .PAGE_SHIFT (PAGE_SHIFT),
      .ADDR_BITS  (ADDR_BITS)
   ) u_geom (
      .clock       (clock),
      .region_base (base_ff),
      .region_size (size_ff),
      .empty       (geom_empty),
      .page_count  (geom_count),
      .last_index  (geom_last),
      .top_pn      (geom_top),
      .low_pn      (geom_low)
   );

   // link memory: {allocated mark, next link} per tracked page
   pfla_ram #(
      .WIDTH (ENT_W),
      .DEPTH (MAX_PAGES)
   ) u_links (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         size_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BASE: base_ff <= csr_wdata;
            CSR_SIZE: size_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // free address: page number, tracked range check, entry index
   assign free_addr_m = addr_ff & ADDR_MASK[ADDR_W-1:0];
   assign free_pn     = PN_W'(free_addr_m >> PAGE_SHIFT);
   assign free_hit    = (free_addr_m != '0) && (free_pn < top_ff) && (free_pn >= low_ff);
   assign free_slot   = IDX_W'(top_ff - free_pn - PN_W'(1));

   // allocated page address from the popped entry
   assign alloc_pn   = top_ff - (PN_W'(slot_ff) + PN_W'(1));
   assign alloc_full = {alloc_pn, {PAGE_SHIFT{1'b0}}} & ADDR_MASK;

   // control and next state
   always_comb begin
      state_in     = state_ff;
      ready_in     = ready_ff;
      head_in      = head_ff;
      free_in      = free_ff;
      tracked_in   = tracked_ff;
      top_in       = top_ff;
      low_in       = low_ff;
      fill_in      = fill_ff;
      slot_in      = slot_ff;
      addr_in      = addr_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = fill_ff;
      ram_wr_data  = '0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = head_ff;
      done         = 1'b0;
      status_c     = ST_OK;
      out_addr_c   = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               addr_in = req_item.page_addr_in;
               case (req_item.action)
                  ACT_INIT: begin
                     state_in = S_INIT_GEOM;
                  end
                  ACT_ALLOC: begin
                     if (!ready_ff) begin
                        done     = 1'b1;
                        status_c = ST_NOT_INIT;
                     end else if (free_ff == '0) begin
                        done     = 1'b1;
                        status_c = ST_NO_FREE;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = head_ff;
                        slot_in     = head_ff;
                        state_in    = S_ALLOC_WR;
                     end
                  end
                  ACT_FREE: begin
                     if (!ready_ff) begin
                        done     = 1'b1;
                        status_c = ST_NOT_INIT;
                     end else begin
                        state_in = S_FREE_RD;
                     end
                  end
                  default: begin
                     done = 1'b1;
                  end
               endcase
            end
         end
         S_INIT_GEOM: begin
            state_in = S_INIT_CHK;
         end
         S_INIT_CHK: begin
            if (geom_empty) begin
               done     = 1'b1;
               status_c = ST_EMPTY_REGION;
               state_in = S_IDLE;
            end else begin
               top_in     = geom_top;
               low_in     = geom_low;
               tracked_in = geom_count;
               free_in    = geom_count;
               head_in    = geom_last;
               ready_in   = 1'b1;
               fill_in    = '0;
               state_in   = S_INIT_FILL;
            end
         end
         S_INIT_FILL: begin
            // entry i links to i - 1; the lowest address ends up at the head
            ram_wr_en   = 1'b1;
            ram_wr_addr = fill_ff;
            ram_wr_data = {1'b0, (fill_ff == '0) ? IDX_W'(0) : fill_ff - IDX_W'(1)};
            fill_in     = fill_ff + IDX_W'(1);
            if (fill_ff == head_ff) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_ALLOC_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = slot_ff;
            ram_wr_data = {1'b1, ram_rd_data[IDX_W-1:0]};
            head_in     = ram_rd_data[IDX_W-1:0];
            free_in     = free_ff - CNT_W'(1);
            out_addr_c  = alloc_full[ADDR_W-1:0];
            done        = 1'b1;
            state_in    = S_IDLE;
         end
         S_FREE_RD: begin
            if (!free_hit) begin
               done     = 1'b1;
               status_c = ST_UNTRACKED;
               state_in = S_IDLE;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = free_slot;
               slot_in     = free_slot;
               state_in    = S_FREE_WR;
            end
         end
         S_FREE_WR: begin
            if (!ram_rd_data[IDX_W]) begin
               status_c = ST_ALREADY_FREE;
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = slot_ff;
               ram_wr_data = {1'b0, head_ff};
               head_in     = slot_ff;
               free_in     = free_ff + CNT_W'(1);
            end
            done     = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in         = done;
      rsp_in.status        = status_c;
      rsp_in.page_addr_out = out_addr_c;
      rsp_in.free_pages    = CNT_OUT_W'(free_in);
      rsp_in.total_pages   = CNT_OUT_W'(tracked_in);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ready_ff     <= 1'b0;
         head_ff      <= '0;
         free_ff      <= '0;
         tracked_ff   <= '0;
         top_ff       <= '0;
         low_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ready_ff     <= ready_in;
         head_ff      <= head_in;
         free_ff      <= free_in;
         tracked_ff   <= tracked_in;
         top_ff       <= top_in;
         low_ff       <= low_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers and result payload
   always_ff @(posedge clock) begin
      fill_ff <= fill_in;
      slot_ff <= slot_in;
      addr_ff <= addr_in;
      if (rsp_valid_in) begin
         rsp_ff <= rsp_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;
endmodule

// ----- src/pfla_checker.sv -----
// port-level checks of the allocator and their binding to the top level
`include "page_free_list_allocator_defines.svh"

module pfla_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           rsp_valid,
   input pfla_pkg::rsp_type              rsp_item
);
   import pfla_pkg::*;

   // a result only follows a transfer in or a working cycle
   `PFLA_ASSERT(a_rsp_has_cause, rsp_valid, $past(busy) || $past(start && !busy))

   // finishing work always produces a result
   `PFLA_ASSERT(a_done_gives_rsp, $fell(busy) && !$past(reset), rsp_valid)

   // failed items never carry an address
   `PFLA_ASSERT(a_fail_zero_addr, rsp_valid && (rsp_item.status != ST_OK), rsp_item.page_addr_out == '0)

   // reset leaves the block idle and quiet
   `PFLA_ASSERT_NEXT(a_reset_quiet, reset, !rsp_valid && !busy)
endmodule

bind page_free_list_allocator pfla_checker u_pfla_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);

// ----- test/page_free_list_allocator_test.sv -----
// testbench for the page free list allocator: directed and random traffic checked against a predictor
`timescale 1ns / 100ps

module page_free_list_allocator_test;
   import pfla_pkg::*;

   localparam int MAX_PAGES    = 16384;
   localparam int PAGE_SHIFT   = 12;
   localparam int PAGE_BYTES   = 1 << PAGE_SHIFT;
   localparam int PN_W         = ADDR_W - PAGE_SHIFT;
   localparam int LINK_W       = 14;
   localparam int RANDOM_ITEMS = 400;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_LIMIT  = 40000;
   localparam int SETTLE_CYCLES = 20;
   localparam int REPORT_LINES = 40;
   localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
   localparam logic [ADDR_W-1:0] ADDR_MAX = {ADDR_W{1'b1}};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_item = '0;
   logic rsp_valid;
   rsp_type rsp_item;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [ADDR_W-1:0] csr_wdata = '0;

   // mirror of what start was last driven to
   bit start_on = 1'b0;
   int unsigned mismatch_count = 0;
   int unsigned items_sent = 0;
   int unsigned cycle_count = 0;
   int unsigned big_inits = 0;

   // predictor state
   logic [ADDR_W-1:0] region_base = '0;
   logic [ADDR_W-1:0] region_size = '0;
   logic [LINK_W-1:0] link_mem [MAX_PAGES];
   bit page_held [MAX_PAGES];
   logic [LINK_W-1:0] head_idx = '0;
   bit list_live = 1'b0;
   int unsigned free_cnt = 0;
   int unsigned track_cnt = 0;
   logic [PN_W-1:0] top_pn = '0;
   bit is_ready = 1'b0;

   // expected replies in order, and pages handed out and not yet freed
   rsp_type pending_replies[$];
   logic [ADDR_W-1:0] held_pages[$];
   rsp_type reply_want;

   page_free_list_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic flag_mismatch(input string what, input logic [ADDR_W-1:0] got,
                                input logic [ADDR_W-1:0] want);
      if (mismatch_count < REPORT_LINES)
         $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
      mismatch_count++;
   endtask

   function automatic logic [ADDR_W-1:0] rand48();
      return ADDR_W'({$urandom, $urandom});
   endfunction

   // address of the page tracked by entry d
   function automatic logic [ADDR_W-1:0] page_of_entry(input int unsigned d);
      return {top_pn - PN_W'(1) - PN_W'(d), {PAGE_SHIFT{1'b0}}};
   endfunction

   // next allocator reply for one accepted item, updating the predicted state
   function automatic rsp_type compute_page_reply(input req_type item);
      rsp_type r;
      logic [ADDR_W-1:0] base_up, top_addr;
      logic [PN_W-1:0] lo_pn, hi_pn, pn, slot_off;
      logic [LINK_W-1:0] e;
      int unsigned n;
      r = '0;
      r.status = ST_OK;
      case (item.action)
         ACT_INIT: begin
            // rounding happens after the address sum wraps
            base_up = region_base + ADDR_W'(PAGE_BYTES - 1);
            top_addr = region_base + region_size;
            lo_pn = base_up[ADDR_W-1:PAGE_SHIFT];
            hi_pn = top_addr[ADDR_W-1:PAGE_SHIFT];
            if (hi_pn <= lo_pn) begin
               r.status = ST_EMPTY_REGION;
            end else begin
               n = (hi_pn - lo_pn > PN_W'(MAX_PAGES)) ? MAX_PAGES : 32'(hi_pn - lo_pn);
               for (int i = 0; i < n; i++) begin
                  link_mem[i] = (i == 0) ? '0 : LINK_W'(i - 1);
                  page_held[i] = 1'b0;
               end
               top_pn = hi_pn;
               track_cnt = n;
               free_cnt = n;
               head_idx = LINK_W'(n - 1);
               list_live = 1'b1;
               is_ready = 1'b1;
            end
         end
         ACT_ALLOC: begin
            if (!is_ready) begin
               r.status = ST_NOT_INIT;
            end else if (free_cnt == 0 || !list_live) begin
               r.status = ST_NO_FREE;
            end else begin
               e = head_idx;
               page_held[e] = 1'b1;
               r.page_addr_out = page_of_entry(e);
               free_cnt--;
               if (free_cnt == 0) list_live = 1'b0;
               else head_idx = link_mem[e];
            end
         end
         ACT_FREE: begin
            pn = item.page_addr_in[ADDR_W-1:PAGE_SHIFT];
            if (!is_ready) begin
               r.status = ST_NOT_INIT;
            end else if (item.page_addr_in == '0 || pn >= top_pn) begin
               r.status = ST_UNTRACKED;
            end else begin
               slot_off = top_pn - PN_W'(1) - pn;
               if (slot_off >= PN_W'(track_cnt)) begin
                  r.status = ST_UNTRACKED;
               end else if (!page_held[slot_off[LINK_W-1:0]]) begin
                  r.status = ST_ALREADY_FREE;
               end else begin
                  // push back on the head of the list
                  page_held[slot_off[LINK_W-1:0]] = 1'b0;
                  link_mem[slot_off[LINK_W-1:0]] = list_live ? head_idx : '0;
                  head_idx = slot_off[LINK_W-1:0];
                  list_live = 1'b1;
                  free_cnt++;
               end
            end
         end
         default: begin
         end
      endcase
      r.free_pages = CNT_OUT_W'(free_cnt);
      r.total_pages = CNT_OUT_W'(track_cnt);
      return r;
   endfunction

   // one request transfer, then the sender's burst and gap pattern
   int unsigned burst_left = 1;
   task automatic send_request(input logic [ACT_W-1:0] action, input logic [ADDR_W-1:0] addr);
      req_type item;
      rsp_type want;
      int unsigned gap;
      item.action = action;
      item.page_addr_in = addr;
      start_on = 1'b1;
      start <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (busy);
      want = compute_page_reply(item);
      pending_replies.push_back(want);
      items_sent++;
      if (action == ACT_ALLOC && want.status == ST_OK) held_pages.push_back(want.page_addr_out);
      if (action == ACT_INIT && want.status == ST_OK) held_pages.delete();
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 6) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
         gap = $urandom_range(0, 5);
         if (gap > 0) begin
            start_on = 1'b0;
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // wait for every reply and an idle block
   task automatic drain_replies();
      if (start_on) begin
         start_on = 1'b0;
         start <= 1'b0;
      end
      while (pending_replies.size() != 0) @(posedge clock);
      while (busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // raise the register write channel and hold until the transfer
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [ADDR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_BASE) region_base = value;
      else region_size = value;
   endtask

   task automatic program_region(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] size,
                                 input bit write_base, input bit write_size);
      drain_replies();
      if (write_base) write_register(CSR_BASE, base);
      if (write_size) write_register(CSR_SIZE, size);
      csr_valid <= 1'b0;
   endtask

   // reply checker: every strobe must match the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_replies.size() == 0) begin
            flag_mismatch("reply with nothing expected", rsp_item.page_addr_out, '0);
         end else begin
            reply_want = pending_replies.pop_front();
            if (rsp_item.status !== reply_want.status)
               flag_mismatch("status", rsp_item.status, reply_want.status);
            if (rsp_item.page_addr_out !== reply_want.page_addr_out)
               flag_mismatch("page_addr_out", rsp_item.page_addr_out, reply_want.page_addr_out);
            if (rsp_item.free_pages !== reply_want.free_pages)
               flag_mismatch("free_pages", rsp_item.free_pages, reply_want.free_pages);
            if (rsp_item.total_pages !== reply_want.total_pages)
               flag_mismatch("total_pages", rsp_item.total_pages, reply_want.total_pages);
         end
      end
   end

   // alloc, free and the unused action before any init, then init of a zero region
   task automatic test_before_init();
      send_request(ACT_ALLOC, '0);
      send_request(ACT_FREE, 48'h0000_0000_3000);
      send_request(ACT_UNUSED, ADDR_MAX);
      send_request(ACT_INIT, '0);
   endtask

   // four pages from an unaligned base: pop order, repeat free, range edges, rebuild
   task automatic test_small_region();
      program_region(48'h0000_0000_1234, 48'h0000_0000_5000, 1'b1, 1'b1);
      send_request(ACT_INIT, '0);
      send_request(ACT_ALLOC, '0);
      send_request(ACT_ALLOC, '0);
      send_request(ACT_FREE, 48'h0000_0000_3abc);
      send_request(ACT_FREE, 48'h0000_0000_3000);
      send_request(ACT_ALLOC, '0);
      send_request(ACT_ALLOC, '0);
      send_request(ACT_ALLOC, '0);
      send_request(ACT_ALLOC, '0);
      send_request(ACT_FREE, '0);
      send_request(ACT_FREE, 48'h0000_0000_6000);
      send_request(ACT_FREE, 48'h0000_0000_1fff);
      send_request(ACT_FREE, ADDR_MAX);
      send_request(ACT_FREE, 48'h0000_0000_5fff);
      send_request(ACT_UNUSED, '0);
      send_request(ACT_INIT, '0);
   endtask

   // base sum wraps to a single page at address zero; empty init keeps state
   task automatic test_wrapped_region();
      program_region(ADDR_MAX, 48'h0000_0000_2000, 1'b1, 1'b1);
      send_request(ACT_INIT, '0);
      send_request(ACT_ALLOC, '0);
      send_request(ACT_FREE, '0);
      send_request(ACT_FREE, 48'h0000_0000_0fff);
      program_region(48'h0000_0000_1001, 48'h0000_0000_1000, 1'b1, 1'b1);
      send_request(ACT_INIT, '0);
      send_request(ACT_ALLOC, '0);
   endtask

   // largest region, capped at the page limit, then the all-zero region
   task automatic test_capped_region();
      program_region(ADDR_MAX, ADDR_MAX, 1'b1, 1'b1);
      send_request(ACT_INIT, '0);
      big_inits++;
      send_request(ACT_ALLOC, '0);
      send_request(ACT_FREE, held_pages[0] | ADDR_W'(PAGE_BYTES - 1));
      send_request(ACT_ALLOC, '0);
      program_region('0, '0, 1'b1, 1'b1);
      send_request(ACT_INIT, '0);
   endtask

   // random regions, each followed by a run of allocs and frees with some noise
   task automatic test_random_traffic();
      int unsigned stop_at, kind, run_len, pick, k;
      logic [ADDR_W-1:0] base, size, addr;
      stop_at = items_sent + RANDOM_ITEMS;
      while (items_sent < stop_at) begin
         kind = $urandom_range(0, 19);
         base = rand48();
         size = ADDR_W'($urandom_range(1, 48) * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1));
         if (kind == 0) begin
            size = ADDR_W'($urandom_range(0, PAGE_BYTES - 1));
         end else if (kind == 1) begin
            base = ADDR_MAX - ADDR_W'($urandom_range(0, 4 * PAGE_BYTES));
         end else if (kind == 2 && big_inits < 2) begin
            size = ADDR_MAX;
            big_inits++;
         end
         // an occasional phase changes only the size
         program_region(base, size, kind != 3, 1'b1);
         send_request(ACT_INIT, rand48());
         run_len = $urandom_range(15, 45);
         for (int j = 0; j < run_len && items_sent < stop_at; j++) begin
            pick = $urandom_range(0, 99);
            if (pick < 42) begin
               send_request(ACT_ALLOC, rand48());
            end else if (pick < 72 && held_pages.size() > 0) begin
               k = $urandom_range(0, held_pages.size() - 1);
               addr = held_pages[k] | ADDR_W'($urandom_range(0, PAGE_BYTES - 1));
               held_pages.delete(k);
               send_request(ACT_FREE, addr);
            end else if (pick < 84 && track_cnt > 0) begin
               addr = page_of_entry($urandom_range(0, track_cnt - 1));
               send_request(ACT_FREE, addr | ADDR_W'($urandom_range(0, PAGE_BYTES - 1)));
            end else if (pick < 90) begin
               send_request(ACT_FREE, rand48());
            end else if (pick < 93) begin
               send_request(ACT_FREE, {top_pn, PAGE_SHIFT'($urandom_range(0, PAGE_BYTES - 1))});
            end else if (pick < 95) begin
               send_request(ACT_FREE, '0);
            end else if (pick < 98) begin
               send_request(ACT_UNUSED, rand48());
            end else begin
               send_request(ACT_INIT, rand48());
            end
         end
      end
   endtask

   initial begin
      int unsigned waited;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_before_init();
      test_small_region();
      test_wrapped_region();
      test_capped_region();
      test_random_traffic();
      if (start_on) begin
         start_on = 1'b0;
         start <= 1'b0;
      end
      waited = 0;
      while (pending_replies.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_replies.size() != 0)
         flag_mismatch("replies never seen", ADDR_W'(0), ADDR_W'(pending_replies.size()));
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- page_free_list_allocator.f -----
+incdir+src
src/pfla_pkg.sv
src/pfla_ram.sv
src/pfla_geom.sv
src/page_free_list_allocator.sv
src/pfla_checker.sv
test/page_free_list_allocator_test.sv
